FILE: sv/polar_voltage_correction_assert.svh
// Assertion macros for the polar voltage update block.
`ifndef POLAR_VOLTAGE_CORRECTION_ASSERT_SVH
`define POLAR_VOLTAGE_CORRECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PVC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("polar_voltage_correction: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PVC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("polar_voltage_correction: next-cycle check failed");

`endif

FILE: sv/pvc_pkg.sv
`timescale 1ns / 1ps

package pvc_pkg;

  // Datapath widths: CORDIC x/y with growth headroom, angles with headroom for sums
  localparam int XY_W  = 36;
  localparam int ANG_W = 35;
  localparam int MAG_W = 33;

  // Bus class codes
  localparam logic [1:0] KIND_SLACK = 2'd0;
  localparam logic [1:0] KIND_PV    = 2'd1;
  localparam logic [1:0] KIND_PQ    = 2'd2;

  // Angle constants, Q4.28 radians
  localparam logic signed [ANG_W-1:0] PI_Q      = (ANG_W)'(843314857);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = (ANG_W)'(421657428);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = (ANG_W)'(1686629713);

  // CORDIC gain compensation, Q0.32
  localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] volt_real;
    logic signed [31:0] volt_imag;
    logic signed [31:0] angle_delta;
    logic signed [31:0] magnitude_delta;
    logic               end_of_sweep;
  } bus_t;

  typedef struct packed {
    logic signed [31:0] new_real;
    logic signed [31:0] new_imag;
    logic               currents_stale;
  } upd_t;

  // Vector state handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  // Per-item values that ride along the chain
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] angle_delta;
    logic signed [31:0] magnitude_delta;
    logic               end_of_sweep;
    logic               nonzero;
  } side_t;

  // atan(2^-idx) in Q4.28, rounded; series in Q60, evaluated at elaboration
  function automatic logic [31:0] atan_q28(input int unsigned idx);
    logic [63:0]  acc;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  rem;
    logic [63:0]  quo;
    logic [63:0]  rnd;
    logic [31:0]  res;
    int unsigned  k;
    int unsigned  e;
    int           j;
    acc = '0;
    if (idx == 0) begin
      res = 32'd210828714;
    end else begin
      for (k = 0; k < 31; k++) begin
        e = idx * (2 * k + 1);
        if (e <= 60) begin
          num = 64'd1 << (60 - e);
          den = 64'(2 * k + 1);
          rem = '0;
          quo = '0;
          // restoring long division
          for (j = 63; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= den) begin
              rem    = rem - den;
              quo[j] = 1'b1;
            end
          end
          if (k[0] == 1'b0) begin
            acc = acc + quo;
          end else begin
            acc = acc - quo;
          end
        end
      end
      rnd = acc + 64'h0000_0000_8000_0000;
      res = rnd[63:32];
    end
    return res;
  endfunction

endpackage

FILE: sv/pvc_vec_cell.sv
`timescale 1ns / 1ps

// One vectoring micro-rotation: drives y toward zero, accumulates angle in z
module pvc_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             up_valid,
  input  pvc_pkg::cordic_t up_data,
  input  pvc_pkg::side_t   up_side,
  output logic             dn_valid,
  output pvc_pkg::cordic_t dn_data,
  output pvc_pkg::side_t   dn_side
);

  localparam logic signed [pvc_pkg::ANG_W-1:0] ATAN =
    (pvc_pkg::ANG_W)'(pvc_pkg::atan_q28(STAGE));

  logic signed [pvc_pkg::XY_W-1:0] xs;
  logic signed [pvc_pkg::XY_W-1:0] ys;
  pvc_pkg::cordic_t                nxt;

  // micro-rotation, direction set by the sign of y
  always_comb begin
    xs = up_data.x >>> STAGE;
    ys = up_data.y >>> STAGE;
    if (!up_data.y[pvc_pkg::XY_W-1]) begin
      nxt.x = up_data.x + ys;
      nxt.y = up_data.y - xs;
      nxt.z = up_data.z + ATAN;
    end else begin
      nxt.x = up_data.x - ys;
      nxt.y = up_data.y + xs;
      nxt.z = up_data.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_data <= nxt;
      dn_side <= up_side;
    end
  end

endmodule

FILE: sv/pvc_rot_cell.sv
`timescale 1ns / 1ps

// One rotation micro-rotation: turns the vector by the remaining angle in z
module pvc_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             up_valid,
  input  pvc_pkg::cordic_t up_data,
  input  pvc_pkg::side_t   up_side,
  output logic             dn_valid,
  output pvc_pkg::cordic_t dn_data,
  output pvc_pkg::side_t   dn_side
);

  localparam logic signed [pvc_pkg::ANG_W-1:0] ATAN =
    (pvc_pkg::ANG_W)'(pvc_pkg::atan_q28(STAGE));

  logic signed [pvc_pkg::XY_W-1:0] xs;
  logic signed [pvc_pkg::XY_W-1:0] ys;
  pvc_pkg::cordic_t                nxt;

  // micro-rotation, direction set by the sign of z
  always_comb begin
    xs = up_data.x >>> STAGE;
    ys = up_data.y >>> STAGE;
    if (!up_data.z[pvc_pkg::ANG_W-1]) begin
      nxt.x = up_data.x - ys;
      nxt.y = up_data.y + xs;
      nxt.z = up_data.z - ATAN;
    end else begin
      nxt.x = up_data.x + ys;
      nxt.y = up_data.y - xs;
      nxt.z = up_data.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_data <= nxt;
      dn_side <= up_side;
    end
  end

endmodule

FILE: sv/pvc_polar_adjust.sv
`timescale 1ns / 1ps

// Six-stage block between the two CORDIC chains:
// gain scale, Newton corrections, angle wrap, quadrant fold, rescale.
module pvc_polar_adjust (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             up_valid,
  input  pvc_pkg::cordic_t up_data,
  input  pvc_pkg::side_t   up_side,
  output logic             dn_valid,
  output pvc_pkg::cordic_t dn_data,
  output pvc_pkg::side_t   dn_side
);

  localparam int AW   = pvc_pkg::ANG_W;
  localparam int MW   = pvc_pkg::MAG_W;
  localparam int XU_W = 34;  // vectoring x is nonnegative and below 2^33

  // one step of whole-turn reduction toward [-pi, pi)
  function automatic logic signed [AW-1:0] wrap_step(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    if (a >= pvc_pkg::PI_Q) begin
      r = a - pvc_pkg::TWO_PI_Q;
    end else if (a < -pvc_pkg::PI_Q) begin
      r = a + pvc_pkg::TWO_PI_Q;
    end else begin
      r = a;
    end
    return r;
  endfunction

  logic           vld [1:5];
  pvc_pkg::side_t sd  [1:5];

  // stage payload registers
  logic [XU_W+31:0]       prod1;
  logic signed [AW-1:0]   ang1;
  logic signed [MW-1:0]   mag2;
  logic signed [AW-1:0]   ang2;
  logic signed [MW-1:0]   mag3;
  logic signed [AW-1:0]   ang3;
  logic [MW-1:0]          abs4;
  logic                   neg4;
  logic signed [AW-1:0]   ang4;
  logic [MW+31:0]         prod5;
  logic                   neg5;
  logic signed [AW-1:0]   z5;

  // combinational next values
  logic [XU_W-1:0]        xu;
  logic signed [AW-1:0]   z_in;
  logic signed [AW-1:0]   da_in;
  logic [XU_W+31:0]       prod1_next;
  logic signed [AW-1:0]   ang1_next;
  logic [XU_W+31:0]       rnd2;
  logic signed [MW:0]     sum3;
  logic signed [MW-1:0]   mag3_next;
  logic signed [MW-1:0]   neg_mag;
  logic [MW+31:0]         prod5_next;
  logic signed [AW-1:0]   z5_next;
  logic                   flip5;
  logic [MW+31:0]         rnd6;
  logic signed [pvc_pkg::XY_W-1:0] px6;
  pvc_pkg::cordic_t       out6_next;

  // stage 1: gain product, angle plus correction
  always_comb begin
    xu    = up_side.nonzero ? up_data.x[XU_W-1:0] : '0;
    z_in  = up_side.nonzero ? up_data.z : '0;
    da_in = (up_side.kind == pvc_pkg::KIND_PV || up_side.kind == pvc_pkg::KIND_PQ) ?
            (AW)'(up_side.angle_delta) : '0;
    prod1_next = xu * pvc_pkg::GAIN_INV;
    ang1_next  = z_in + da_in;
  end

  // stage 3: magnitude correction for PQ, saturated to 33 bits
  always_comb begin
    rnd2 = prod1 + (XU_W + 32)'(32'h8000_0000);
    sum3 = (MW + 1)'(mag2) + (MW + 1)'(sd[2].magnitude_delta);
    if (sd[2].kind != pvc_pkg::KIND_PQ) begin
      mag3_next = mag2;
    end else if (sum3[MW] != sum3[MW-1]) begin
      mag3_next = sum3[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
    end else begin
      mag3_next = sum3[MW-1:0];
    end
    neg_mag = -mag3;
  end

  // stage 5: scale magnitude, fold angle into [-pi/2, pi/2]
  always_comb begin
    prod5_next = abs4 * pvc_pkg::GAIN_INV;
    if (ang4 > pvc_pkg::HALF_PI_Q) begin
      z5_next = ang4 - pvc_pkg::PI_Q;
      flip5   = 1'b1;
    end else if (ang4 < -pvc_pkg::HALF_PI_Q) begin
      z5_next = ang4 + pvc_pkg::PI_Q;
      flip5   = 1'b1;
    end else begin
      z5_next = ang4;
      flip5   = 1'b0;
    end
  end

  // stage 6: round, apply sign, start vector on the real axis
  always_comb begin
    rnd6        = prod5 + (MW + 32)'(32'h8000_0000);
    px6         = (pvc_pkg::XY_W)'({1'b0, rnd6[MW+31:32]});
    out6_next.x = neg5 ? -px6 : px6;
    out6_next.y = '0;
    out6_next.z = z5;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 5; i++) begin
        vld[i] <= 1'b0;
      end
      dn_valid <= 1'b0;
    end else if (adv) begin
      vld[1]   <= up_valid;
      for (int i = 2; i <= 5; i++) begin
        vld[i] <= vld[i-1];
      end
      dn_valid <= vld[5];
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[1] <= up_side;
      for (int i = 2; i <= 5; i++) begin
        sd[i] <= sd[i-1];
      end
      dn_side <= sd[5];
      prod1   <= prod1_next;
      ang1    <= ang1_next;
      mag2    <= $signed({1'b0, rnd2[63:32]});
      ang2    <= wrap_step(ang1);
      mag3    <= mag3_next;
      ang3    <= wrap_step(ang2);
      abs4    <= mag3[MW-1] ? $unsigned(neg_mag) : $unsigned(mag3);
      neg4    <= mag3[MW-1];
      ang4    <= wrap_step(ang3);
      prod5   <= prod5_next;
      neg5    <= neg4 ^ flip5;
      z5      <= z5_next;
      dn_data <= out6_next;
    end
  end

endmodule

FILE: sv/polar_voltage_correction.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload   Moves
// bus       bus_valid/bus_ready    bus_data  one bus per transfer in
// upd       upd_valid/upd_ready    upd_data  one corrected voltage per transfer out
//
// Takes one bus per cycle while bus_ready is high; each result passes through
// 2*CORDIC_STAGES+8 registers: input stage, the two CORDIC
// cell chains, six middle stages and the output stage.
// Reset (rst, synchronous) empties the pipeline and the output stage.
// A stalled output holds its result; one more result lands in the skid register,
// then bus_ready drops until the skid register drains.
module polar_voltage_correction #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          bus_valid,
  output logic          bus_ready,
  input  pvc_pkg::bus_t bus_data,
  output logic          upd_valid,
  input  logic          upd_ready,
  output pvc_pkg::upd_t upd_data
);

`include "polar_voltage_correction_assert.svh"

  localparam int XW = pvc_pkg::XY_W;

  // 32-bit saturation of a CORDIC output
  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    if (v[XW-1:31] == {(XW-31){1'b0}} || v[XW-1:31] == {(XW-31){1'b1}}) begin
      r = v[31:0];
    end else if (v[XW-1]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  logic adv;
  logic land;
  logic take;

  logic signed [XW-1:0] vr;
  logic signed [XW-1:0] vi;
  pvc_pkg::cordic_t     pre_next;
  pvc_pkg::side_t       pre_side_next;
  logic                 pre_valid;
  pvc_pkg::cordic_t     pre_data;
  pvc_pkg::side_t       pre_side;

  logic             vec_v [0:CORDIC_STAGES];
  pvc_pkg::cordic_t vec_d [0:CORDIC_STAGES];
  pvc_pkg::side_t   vec_s [0:CORDIC_STAGES];
  logic             rot_v [0:CORDIC_STAGES];
  pvc_pkg::cordic_t rot_d [0:CORDIC_STAGES];
  pvc_pkg::side_t   rot_s [0:CORDIC_STAGES];

  pvc_pkg::upd_t res;
  pvc_pkg::upd_t skid_data;
  logic          skid_valid;

  assign adv       = !skid_valid;
  assign bus_ready = adv;
  assign take      = upd_valid && upd_ready;
  assign land      = adv && rot_v[CORDIC_STAGES];

  // input stage: move left half-plane vectors to the right half-plane
  always_comb begin
    vr = (XW)'(bus_data.volt_real);
    vi = (XW)'(bus_data.volt_imag);
    if (vr[XW-1]) begin
      pre_next.x = -vr;
      pre_next.y = -vi;
      pre_next.z = vi[XW-1] ? -pvc_pkg::PI_Q : pvc_pkg::PI_Q;
    end else begin
      pre_next.x = vr;
      pre_next.y = vi;
      pre_next.z = '0;
    end
    pre_side_next.kind            = bus_data.kind;
    pre_side_next.angle_delta     = bus_data.angle_delta;
    pre_side_next.magnitude_delta = bus_data.magnitude_delta;
    pre_side_next.end_of_sweep    = bus_data.end_of_sweep;
    pre_side_next.nonzero         = (bus_data.volt_real != '0) || (bus_data.volt_imag != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (adv) begin
      pre_valid <= bus_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_data <= pre_next;
      pre_side <= pre_side_next;
    end
  end

  assign vec_v[0] = pre_valid;
  assign vec_d[0] = pre_data;
  assign vec_s[0] = pre_side;

  // vectoring chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    pvc_vec_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (vec_v[g]),
      .up_data  (vec_d[g]),
      .up_side  (vec_s[g]),
      .dn_valid (vec_v[g+1]),
      .dn_data  (vec_d[g+1]),
      .dn_side  (vec_s[g+1])
    );
  end

  pvc_polar_adjust u_adjust (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .up_valid (vec_v[CORDIC_STAGES]),
    .up_data  (vec_d[CORDIC_STAGES]),
    .up_side  (vec_s[CORDIC_STAGES]),
    .dn_valid (rot_v[0]),
    .dn_data  (rot_d[0]),
    .dn_side  (rot_s[0])
  );

  // rotation chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    pvc_rot_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (rot_v[g]),
      .up_data  (rot_d[g]),
      .up_side  (rot_s[g]),
      .dn_valid (rot_v[g+1]),
      .dn_data  (rot_d[g+1]),
      .dn_side  (rot_s[g+1])
    );
  end

  // saturate into the result format
  always_comb begin
    res.new_real       = sat32(rot_d[CORDIC_STAGES].x);
    res.new_imag       = sat32(rot_d[CORDIC_STAGES].y);
    res.currents_stale = rot_s[CORDIC_STAGES].end_of_sweep;
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (land) begin
      if (!upd_valid || take) begin
        upd_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      upd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        upd_data <= skid_data;
      end
    end else if (land) begin
      if (!upd_valid || take) begin
        upd_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  // checks
  `PVC_ASSERT_NOW(a_skid_needs_main, clk, rst, skid_valid, upd_valid)
  `PVC_ASSERT_NOW(a_skid_blocks_input, clk, rst, skid_valid, !bus_ready)
  `PVC_ASSERT_NEXT(a_result_lands, clk, rst, land, upd_valid)

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int STAGES    = 24;
  localparam int LATENCY   = 2 * STAGES + 7;
  localparam int LIMIT     = 200000;
  localparam int N_RANDOM  = 630;
  localparam int QUIET_AT  = 560;   // transfers after which nobody idles
  localparam int LONG_HOLD = 400;

  // Spare class code, corrects nothing
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Q4.28 values used by the directed transfers
  localparam logic signed [31:0] ONE  = 32'sd268435456;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  // Angle and gain constants of the fixed-point update
  localparam longint PI_Q28        = 64'sd843314857;
  localparam longint HALF_PI_Q28   = 64'sd421657428;
  localparam longint TWO_PI_Q28    = 64'sd1686629713;
  localparam longint unsigned GAIN = 64'd2608131496;

  class voltage_scoreboard;
    pvc_pkg::upd_t pending_updates[$];
    longint        atan_tab[32];
    int            mismatch_count;

    // atan(2^-i) from its series in Q60, rounded to Q4.28
    function new();
      longint unsigned acc;
      longint unsigned term;
      int unsigned     k;
      int unsigned     e;
      mismatch_count = 0;
      atan_tab[0] = 64'sd210828714;
      for (int unsigned i = 1; i < 32; i++) begin
        acc = 0;
        k = 0;
        e = i;
        while (e <= 60) begin
          term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
          if (k[0] == 1'b0) begin
            acc = acc + term;
          end else begin
            acc = acc - term;
          end
          k = k + 1;
          e = i * (2 * k + 1);
        end
        atan_tab[i] = longint'((acc + 64'h8000_0000) >> 32);
      end
    endfunction

    // Magnitude times the inverse CORDIC gain, rounded half away from zero
    function longint scale_gain(longint v);
      longint unsigned a;
      longint unsigned p;
      a = (v < 0) ? longint'(-v) : v;
      p = (a * GAIN + 64'h8000_0000) >> 32;
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return SMAX;
      if (v < -64'sd2147483648) return SMIN;
      return v[31:0];
    endfunction

    // Polar round trip with the Newton corrections of the bus class
    function pvc_pkg::upd_t corrected_voltage(pvc_pkg::bus_t b);
      longint        x, y, z, mag, ang, xs, ys;
      pvc_pkg::upd_t r;
      x = longint'(b.volt_real);
      y = longint'(b.volt_imag);
      z = 0;
      mag = 0;
      ang = 0;
      // vectoring; zero voltage keeps magnitude and angle at zero
      if (x != 0 || y != 0) begin
        if (x < 0) begin
          z = (y >= 0) ? PI_Q28 : -PI_Q28;
          x = -x;
          y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_tab[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_tab[i];
          end
        end
        mag = scale_gain(x);
        ang = z;
      end
      // corrections: angle for PV and PQ, magnitude for PQ only
      if (b.kind == pvc_pkg::KIND_PV || b.kind == pvc_pkg::KIND_PQ)
        ang = ang + longint'(b.angle_delta);
      if (b.kind == pvc_pkg::KIND_PQ) begin
        mag = mag + longint'(b.magnitude_delta);
        if (mag > 64'sd4294967295) mag = 64'sd4294967295;
        if (mag < -64'sd4294967296) mag = -64'sd4294967296;
      end
      while (ang >= PI_Q28) ang = ang - TWO_PI_Q28;
      while (ang < -PI_Q28) ang = ang + TWO_PI_Q28;
      // rotation back to rectangular, folded into the right half plane
      x = scale_gain(mag);
      y = 0;
      if (ang > HALF_PI_Q28) begin
        ang = ang - PI_Q28;
        x = -x;
      end else if (ang < -HALF_PI_Q28) begin
        ang = ang + PI_Q28;
        x = -x;
      end
      z = ang;
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_tab[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_tab[i];
        end
      end
      r.new_real = clip32(x);
      r.new_imag = clip32(y);
      r.currents_stale = b.end_of_sweep;
      return r;
    endfunction

    function void note_bus(pvc_pkg::bus_t b);
      pending_updates.push_back(corrected_voltage(b));
    endfunction

    function void check_update(pvc_pkg::upd_t got);
      pvc_pkg::upd_t want;
      if (pending_updates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: update with none pending: real %0d imag %0d stale %0b",
                   got.new_real, got.new_imag, got.currents_stale);
        return;
      end
      want = pending_updates.pop_front();
      if (got.new_real !== want.new_real || got.new_imag !== want.new_imag ||
          got.currents_stale !== want.currents_stale) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: update mismatch: real %0d/%0d imag %0d/%0d stale %0b/%0b (exp/act)",
                   want.new_real, got.new_real, want.new_imag, got.new_imag,
                   want.currents_stale, got.currents_stale);
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          bus_valid = 1'b0;
  logic          upd_ready = 1'b0;
  pvc_pkg::bus_t bus_data  = '0;
  logic          bus_ready;
  logic          upd_valid;
  pvc_pkg::upd_t upd_data;

  voltage_scoreboard sb = new();
  int cycle_count = 0;
  int sent_count  = 0;
  int gap_pct     = 10;

  always #2 clk = ~clk;

  polar_voltage_correction #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .bus_valid (bus_valid),
    .bus_ready (bus_ready),
    .bus_data  (bus_data),
    .upd_valid (upd_valid),
    .upd_ready (upd_ready),
    .upd_data  (upd_data)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic pvc_pkg::bus_t make_bus(logic [1:0] kind, logic signed [31:0] re,
                                             logic signed [31:0] im,
                                             logic signed [31:0] da,
                                             logic signed [31:0] dm, logic eos);
    pvc_pkg::bus_t b;
    b.kind = kind;
    b.volt_real = re;
    b.volt_imag = im;
    b.angle_delta = da;
    b.magnitude_delta = dm;
    b.end_of_sweep = eos;
    return b;
  endfunction

  // Mostly buses near nominal voltage with small corrections, some raw noise
  function automatic pvc_pkg::bus_t random_bus();
    pvc_pkg::bus_t b;
    b.kind = ($urandom_range(0, 19) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
    b.end_of_sweep = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) < 7) begin
      b.volt_real = 32'($urandom_range(0, 671088640)) - 32'sd335544320;
      b.volt_imag = 32'($urandom_range(0, 671088640)) - 32'sd335544320;
      b.angle_delta = 32'($urandom_range(0, 134217728)) - 32'sd67108864;
      b.magnitude_delta = 32'($urandom_range(0, 67108864)) - 32'sd33554432;
    end else begin
      b.volt_real = $urandom;
      b.volt_imag = $urandom;
      b.angle_delta = $urandom;
      b.magnitude_delta = $urandom;
    end
    if ($urandom_range(0, 39) == 0) begin
      b.volt_real = '0;
      b.volt_imag = '0;
    end
    return b;
  endfunction

  // Offer one bus, with an occasional idle burst first, and hold it until taken
  task automatic send_bus(pvc_pkg::bus_t b);
    if (sent_count % 50 == 0) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 25;
      endcase
    end
    if (sent_count < QUIET_AT && $urandom_range(0, 99) < gap_pct) begin
      bus_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    bus_valid <= 1'b1;
    bus_data  <= b;
    do @(posedge clk); while (!bus_ready);
    sb.note_bus(b);
    sent_count++;
  endtask

  // Result side: random stalls, one long hold-off to back up the pipeline
  initial begin : receiver
    int  stall_left;
    int  stall_pct;
    int  results;
    bit  long_done;
    stall_left = 0;
    stall_pct  = 10;
    results    = 0;
    long_done  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (upd_valid && upd_ready) begin
        sb.check_update(upd_data);
        results++;
      end
      if (cycle_count % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      if (!long_done && results >= 150) begin
        long_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && sent_count < QUIET_AT &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      upd_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero voltage, with and without a magnitude correction
    send_bus(make_bus(pvc_pkg::KIND_SLACK, 0, 0, SMAX, SMAX, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, 0, 0, ONE, SMAX, 1'b1));
    send_bus(make_bus(pvc_pkg::KIND_PQ, 0, 0, -ONE, SMIN, 1'b0));
    // field extremes and negative real part on both sides of the axis
    send_bus(make_bus(pvc_pkg::KIND_SLACK, SMAX, 0, 0, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_SLACK, SMIN, 0, 0, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PV, SMIN, -1, 0, 0, 1'b1));
    send_bus(make_bus(pvc_pkg::KIND_SLACK, 0, SMIN, 0, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_SLACK, 0, SMAX, 0, 0, 1'b0));
    // output overflow, magnitude saturation
    send_bus(make_bus(pvc_pkg::KIND_SLACK, SMAX, SMAX, 0, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, SMIN, SMIN, SMAX, SMAX, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, SMAX, SMIN, SMIN, SMAX, 1'b1));
    // negative magnitude after correction
    send_bus(make_bus(pvc_pkg::KIND_PQ, ONE, 0, 0, SMIN, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, ONE >>> 2, ONE >>> 3, ONE >>> 1, -ONE, 1'b0));
    // angle wrap past +pi and below -pi, several turns with extreme deltas
    send_bus(make_bus(pvc_pkg::KIND_PV, -ONE, 1, ONE, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PV, -ONE, -1, -ONE, 0, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, -ONE, ONE, SMAX, ONE >>> 4, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PV, -ONE, -ONE, SMIN, SMAX, 1'b1));
    // spare class corrects nothing
    send_bus(make_bus(KIND_SPARE, ONE, -ONE, SMAX, SMAX, 1'b1));
    send_bus(make_bus(KIND_SPARE, -ONE, ONE, SMIN, SMIN, 1'b0));
    // nominal buses, one of each class
    send_bus(make_bus(pvc_pkg::KIND_SLACK, ONE, 0, ONE >>> 5, ONE >>> 6, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PV, ONE, ONE >>> 4, -(ONE >>> 5), ONE >>> 6, 1'b0));
    send_bus(make_bus(pvc_pkg::KIND_PQ, -(ONE >>> 4), ONE, ONE >>> 5, -(ONE >>> 6), 1'b1));

    for (int n = 0; n < N_RANDOM; n++) send_bus(random_bus());
    bus_valid <= 1'b0;

    // drain, then let the pipeline run dry
    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/pvc_pkg.sv
sv/pvc_vec_cell.sv
sv/pvc_rot_cell.sv
sv/pvc_polar_adjust.sv
sv/polar_voltage_correction.sv
bench/testbench.sv
